@@ rtl/core/sm83_alu_with_flags_assert.svh @@
// Assertion macros for the SM83 ALU pipeline.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef SM83_ALU_WITH_FLAGS_ASSERT_SVH
`define SM83_ALU_WITH_FLAGS_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SM83_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SM83_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sm83_alu_pkg.sv @@
// Shared types and constants for the SM83 ALU pipeline.
// No dependencies; used by every module of the block, not by the interfaces.
`default_nettype none

package sm83_alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_XOR    = 5'd5,
    OP_OR     = 5'd6,
    OP_CP     = 5'd7,
    OP_INC    = 5'd8,
    OP_DEC    = 5'd9,
    OP_DAA    = 5'd10,
    OP_CPL    = 5'd11,
    OP_SCF    = 5'd12,
    OP_CCF    = 5'd13,
    OP_RLC    = 5'd14,
    OP_RRC    = 5'd15,
    OP_RL     = 5'd16,
    OP_RR     = 5'd17,
    OP_SLA    = 5'd18,
    OP_SRA    = 5'd19,
    OP_SWAP   = 5'd20,
    OP_SRL    = 5'd21,
    OP_BIT    = 5'd22,
    OP_RES    = 5'd23,
    OP_SET    = 5'd24,
    OP_RLCA   = 5'd25,
    OP_RRCA   = 5'd26,
    OP_RLA    = 5'd27,
    OP_RRA    = 5'd28,
    OP_ADD16  = 5'd29,
    OP_ADD_SP = 5'd30
  } op_t;

  localparam logic [7:0] DAA_ADJ_LO   = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI   = 8'h60;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

  typedef struct packed {
    op_t         op;
    logic [15:0] left;
    logic [15:0] right;
    logic [2:0]  bit_index;
    logic        zi;
    logic        ni;
    logic        hi;
    logic        ci;
  } item_t;

  // Adder results, registered after the first stage
  typedef struct packed {
    item_t       item;
    logic [8:0]  add9;
    logic        add_h;
    logic [8:0]  sub9;
    logic        sub_h;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  daa8;
    logic        daa_c;
    logic [16:0] add17;
    logic        add16_h;
    logic [15:0] sp_sum;
    logic        sp_h;
    logic        sp_c;
  } arith_t;

  // Selected result, zero flag still to be resolved
  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  zval;
    logic        z_calc;
    logic        z_fix;
    logic        n;
    logic        h;
    logic        c;
    logic        wide;
  } sel_t;

  typedef struct packed {
    logic [15:0] result;
    logic        zero;
    logic        sub;
    logic        half;
    logic        carry;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/core/sm83_alu_if.sv @@
// Valid/ready channel interfaces for the SM83 ALU: operation in, result out.
// Depends on nothing but the widths of the item fields.
`default_nettype none

interface sm83_alu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic [15:0] left;
  logic [15:0] right;
  logic [2:0]  bit_index;
  logic        zero_in;
  logic        sub_in;
  logic        half_in;
  logic        carry_in;

  modport source (output valid, op, left, right, bit_index, zero_in, sub_in, half_in,
                  carry_in, input ready);
  modport sink (input valid, op, left, right, bit_index, zero_in, sub_in, half_in,
                carry_in, output ready);
endinterface

interface sm83_alu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic        zero_out;
  logic        sub_out;
  logic        half_out;
  logic        carry_out;

  modport source (output valid, result, zero_out, sub_out, half_out, carry_out,
                  input ready);
  modport sink (input valid, result, zero_out, sub_out, half_out, carry_out,
                output ready);
endinterface

`default_nettype wire

@@ rtl/core/sm83_alu_exec.sv @@
// First pipeline stage of the SM83 ALU: all adders and the decimal adjust.
// Depends on sm83_alu_pkg.
`default_nettype none

module sm83_alu_exec (
  input  wire sm83_alu_pkg::item_t  item,
  output sm83_alu_pkg::arith_t      arith
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cy;
  logic [4:0]  add_lo;
  logic [4:0]  sub_lo;
  logic [12:0] add12;
  logic [4:0]  sp_lo;
  logic [8:0]  sp_byte;
  logic        adj_lo;
  logic        adj_hi;
  logic [7:0]  adj;

  assign a  = item.left[7:0];
  assign b  = item.right[7:0];
  assign cy = ((item.op == sm83_alu_pkg::OP_ADC) || (item.op == sm83_alu_pkg::OP_SBC))
              & item.ci;

  assign add_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0000, cy};
  assign sub_lo  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0000, cy};
  assign add12   = {1'b0, item.left[11:0]} + {1'b0, item.right[11:0]};
  assign sp_lo   = {1'b0, item.left[3:0]} + {1'b0, b[3:0]};
  assign sp_byte = {1'b0, item.left[7:0]} + {1'b0, b};

  // Decimal adjust works from the incoming N, H and C
  assign adj_lo = item.hi || (!item.ni && (a[3:0] > sm83_alu_pkg::DAA_LO_LIMIT));
  assign adj_hi = item.ci || (!item.ni && (a > sm83_alu_pkg::DAA_HI_LIMIT));
  assign adj    = (adj_lo ? sm83_alu_pkg::DAA_ADJ_LO : 8'h00)
                | (adj_hi ? sm83_alu_pkg::DAA_ADJ_HI : 8'h00);

  always_comb begin
    arith.item    = item;
    arith.add9    = {1'b0, a} + {1'b0, b} + {8'h00, cy};
    arith.add_h   = add_lo[4];
    arith.sub9    = {1'b0, a} - {1'b0, b} - {8'h00, cy};
    arith.sub_h   = sub_lo[4];
    arith.inc8    = a + 8'd1;
    arith.dec8    = a - 8'd1;
    arith.daa8    = item.ni ? (a - adj) : (a + adj);
    arith.daa_c   = adj_hi;
    arith.add17   = {1'b0, item.left} + {1'b0, item.right};
    arith.add16_h = add12[12];
    arith.sp_sum  = item.left + {{8{b[7]}}, b};
    arith.sp_h    = sp_lo[4];
    arith.sp_c    = sp_byte[8];
  end

endmodule

`default_nettype wire

@@ rtl/core/sm83_alu_sel.sv @@
// Second pipeline stage of the SM83 ALU: result and flag selection per operation.
// Depends on sm83_alu_pkg; takes the registered adder results of sm83_alu_exec.
`default_nettype none

module sm83_alu_sel (
  input  wire sm83_alu_pkg::arith_t arith,
  output sm83_alu_pkg::sel_t        sel
);

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] mask;
  logic       zi;
  logic       ni;
  logic       hi;
  logic       ci;

  assign a    = arith.item.left[7:0];
  assign b    = arith.item.right[7:0];
  assign mask = 8'd1 << arith.item.bit_index;
  assign zi   = arith.item.zi;
  assign ni   = arith.item.ni;
  assign hi   = arith.item.hi;
  assign ci   = arith.item.ci;

  always_comb begin
    sel.result = {8'h00, a};
    sel.zval   = a;
    sel.z_calc = 1'b1;
    sel.z_fix  = 1'b0;
    sel.n      = 1'b0;
    sel.h      = 1'b0;
    sel.c      = 1'b0;
    sel.wide   = 1'b0;
    case (arith.item.op)
      sm83_alu_pkg::OP_ADD, sm83_alu_pkg::OP_ADC: begin
        sel.result[7:0] = arith.add9[7:0];
        sel.h           = arith.add_h;
        sel.c           = arith.add9[8];
      end
      sm83_alu_pkg::OP_SUB, sm83_alu_pkg::OP_SBC: begin
        sel.result[7:0] = arith.sub9[7:0];
        sel.n           = 1'b1;
        sel.h           = arith.sub_h;
        sel.c           = arith.sub9[8];
      end
      sm83_alu_pkg::OP_CP: begin
        // keep the accumulator, flag the difference
        sel.zval = arith.sub9[7:0];
        sel.n    = 1'b1;
        sel.h    = arith.sub_h;
        sel.c    = arith.sub9[8];
      end
      sm83_alu_pkg::OP_AND: begin
        sel.result[7:0] = a & b;
        sel.h           = 1'b1;
      end
      sm83_alu_pkg::OP_XOR: sel.result[7:0] = a ^ b;
      sm83_alu_pkg::OP_OR:  sel.result[7:0] = a | b;
      sm83_alu_pkg::OP_INC: begin
        sel.result[7:0] = arith.inc8;
        sel.h           = (a[3:0] == 4'hF);
        sel.c           = ci;
      end
      sm83_alu_pkg::OP_DEC: begin
        sel.result[7:0] = arith.dec8;
        sel.n           = 1'b1;
        sel.h           = (a[3:0] == 4'h0);
        sel.c           = ci;
      end
      sm83_alu_pkg::OP_DAA: begin
        sel.result[7:0] = arith.daa8;
        sel.n           = ni;
        sel.c           = arith.daa_c;
      end
      sm83_alu_pkg::OP_CPL: begin
        sel.result[7:0] = ~a;
        sel.z_calc      = 1'b0;
        sel.z_fix       = zi;
        sel.n           = 1'b1;
        sel.h           = 1'b1;
        sel.c           = ci;
      end
      sm83_alu_pkg::OP_SCF: begin
        sel.z_calc = 1'b0;
        sel.z_fix  = zi;
        sel.c      = 1'b1;
      end
      sm83_alu_pkg::OP_CCF: begin
        sel.z_calc = 1'b0;
        sel.z_fix  = zi;
        sel.c      = ~ci;
      end
      sm83_alu_pkg::OP_RLC, sm83_alu_pkg::OP_RLCA: begin
        sel.result[7:0] = {a[6:0], a[7]};
        sel.z_calc      = (arith.item.op == sm83_alu_pkg::OP_RLC);
        sel.c           = a[7];
      end
      sm83_alu_pkg::OP_RRC, sm83_alu_pkg::OP_RRCA: begin
        sel.result[7:0] = {a[0], a[7:1]};
        sel.z_calc      = (arith.item.op == sm83_alu_pkg::OP_RRC);
        sel.c           = a[0];
      end
      sm83_alu_pkg::OP_RL, sm83_alu_pkg::OP_RLA: begin
        sel.result[7:0] = {a[6:0], ci};
        sel.z_calc      = (arith.item.op == sm83_alu_pkg::OP_RL);
        sel.c           = a[7];
      end
      sm83_alu_pkg::OP_RR, sm83_alu_pkg::OP_RRA: begin
        sel.result[7:0] = {ci, a[7:1]};
        sel.z_calc      = (arith.item.op == sm83_alu_pkg::OP_RR);
        sel.c           = a[0];
      end
      sm83_alu_pkg::OP_SLA: begin
        sel.result[7:0] = {a[6:0], 1'b0};
        sel.c           = a[7];
      end
      sm83_alu_pkg::OP_SRA: begin
        sel.result[7:0] = {a[7], a[7:1]};
        sel.c           = a[0];
      end
      sm83_alu_pkg::OP_SWAP: sel.result[7:0] = {a[3:0], a[7:4]};
      sm83_alu_pkg::OP_SRL: begin
        sel.result[7:0] = {1'b0, a[7:1]};
        sel.c           = a[0];
      end
      sm83_alu_pkg::OP_BIT: begin
        sel.z_calc = 1'b0;
        sel.z_fix  = ~|(a & mask);
        sel.h      = 1'b1;
        sel.c      = ci;
      end
      sm83_alu_pkg::OP_RES, sm83_alu_pkg::OP_SET: begin
        sel.result[7:0] = (arith.item.op == sm83_alu_pkg::OP_SET) ? (a | mask)
                                                                  : (a & ~mask);
        sel.z_calc      = 1'b0;
        sel.z_fix       = zi;
        sel.n           = ni;
        sel.h           = hi;
        sel.c           = ci;
      end
      sm83_alu_pkg::OP_ADD16: begin
        sel.result = arith.add17[15:0];
        sel.z_calc = 1'b0;
        sel.z_fix  = zi;
        sel.h      = arith.add16_h;
        sel.c      = arith.add17[16];
        sel.wide   = 1'b1;
      end
      sm83_alu_pkg::OP_ADD_SP: begin
        sel.result = arith.sp_sum;
        sel.z_calc = 1'b0;
        sel.h      = arith.sp_h;
        sel.c      = arith.sp_c;
        sel.wide   = 1'b1;
      end
      default: begin
        // unknown code: pass the operand and flags through
        sel.result = arith.item.left;
        sel.z_calc = 1'b0;
        sel.z_fix  = zi;
        sel.n      = ni;
        sel.h      = hi;
        sel.c      = ci;
        sel.wide   = 1'b1;
      end
    endcase
    // zero flag follows the byte result; cp keeps its difference instead
    if (arith.item.op != sm83_alu_pkg::OP_CP) begin
      sel.zval = sel.result[7:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sm83_alu_with_flags.sv @@
// SM83 8-bit ALU with flags, three register stages: adders, select, zero flag.
// An accepted item passes the adder, select and zero-flag registers in that order.
// Throughput: one item per cycle; each stage holds under back-pressure and
// takes a new item as soon as the stage after it moves on.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// Depends on sm83_alu_pkg, sm83_alu_if, sm83_alu_exec and sm83_alu_sel.
`default_nettype none
`include "sm83_alu_with_flags_assert.svh"

module sm83_alu_with_flags (
  input  wire logic           clk,
  input  wire logic           rst_n,
  sm83_alu_in_if.sink         in_ch,
  sm83_alu_out_if.source      out_ch
);

  sm83_alu_pkg::item_t  item;
  sm83_alu_pkg::arith_t s1_nxt;
  sm83_alu_pkg::arith_t s1_r;
  sm83_alu_pkg::sel_t   s2_nxt;
  sm83_alu_pkg::sel_t   s2_r;
  sm83_alu_pkg::out_t   out_nxt;
  sm83_alu_pkg::out_t   out_r;

  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic acc1, acc2, acc3;

  assign item.op        = sm83_alu_pkg::op_t'(in_ch.op);
  assign item.left      = in_ch.left;
  assign item.right     = in_ch.right;
  assign item.bit_index = in_ch.bit_index;
  assign item.zi        = in_ch.zero_in;
  assign item.ni        = in_ch.sub_in;
  assign item.hi        = in_ch.half_in;
  assign item.ci        = in_ch.carry_in;

  sm83_alu_exec u_exec (
    .item  (item),
    .arith (s1_nxt)
  );

  sm83_alu_sel u_sel (
    .arith (s1_r),
    .sel   (s2_nxt)
  );

  always_comb begin
    out_nxt.result = s2_r.result;
    out_nxt.zero   = s2_r.z_calc ? (s2_r.zval == 8'h00) : s2_r.z_fix;
    out_nxt.sub    = s2_r.n;
    out_nxt.half   = s2_r.h;
    out_nxt.carry  = s2_r.c;
  end

  // A stage takes a new item when it is empty or its item moves on
  assign acc3 = !v3_r || out_ch.ready;
  assign acc2 = !v2_r || acc3;
  assign acc1 = !v1_r || acc2;

  assign in_ch.ready = acc1;

  always_comb begin
    v1_nxt = acc1 ? in_ch.valid : v1_r;
    v2_nxt = acc2 ? v1_r : v2_r;
    v3_nxt = acc3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc1 && in_ch.valid) begin
      s1_r <= s1_nxt;
    end
    if (acc2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (acc3 && v2_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid     = v3_r;
  assign out_ch.result    = out_r.result;
  assign out_ch.zero_out  = out_r.zero;
  assign out_ch.sub_out   = out_r.sub;
  assign out_ch.half_out  = out_r.half;
  assign out_ch.carry_out = out_r.carry;

  `SM83_ASSERT_NEXT(a_enter_s1, in_ch.valid && acc1, v1_r,
                    "accepted item missing from first stage")
  `SM83_ASSERT_NEXT(a_adv_s2, v1_r && acc2, v2_r,
                    "item lost between first and second stage")
  `SM83_ASSERT_NEXT(a_hold_s2, v2_r && !acc3, v2_r && $stable(s2_r),
                    "second stage changed while stalled")
  `SM83_ASSERT_NOW(a_byte_ops, v2_r && !s2_r.wide, s2_r.result[15:8] == 8'h00,
                   "byte operation produced a non-zero high byte")

endmodule

`default_nettype wire

@@ tb/sv/tb_sm83_alu_with_flags.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sm83_alu_with_flags. It predicts the value and flags
// of each operation and checks the results in order.
// Needs sm83_alu_pkg, the channel interfaces and the RTL.

class alu_checker;
  sm83_alu_pkg::out_t pending_outs[$];
  bit [30:0]          ops_seen;
  int                 n_ops;
  int                 n_checked;
  int                 n_fails;

  function sm83_alu_pkg::out_t pack8(logic [7:0] r8, logic z, logic n, logic h, logic c);
    sm83_alu_pkg::out_t o;
    o.result = {8'h00, r8};
    o.zero   = z;
    o.sub    = n;
    o.half   = h;
    o.carry  = c;
    return o;
  endfunction

  function sm83_alu_pkg::out_t alu_eval(sm83_alu_pkg::item_t it);
    logic [7:0]         a;
    logic [7:0]         b;
    logic [7:0]         r8;
    logic [7:0]         msk;
    logic [7:0]         adj;
    logic [8:0]         s9;
    logic [4:0]         h5;
    logic [12:0]        h13;
    logic [16:0]        s17;
    logic               cy;
    sm83_alu_pkg::out_t o;
    a   = it.left[7:0];
    b   = it.right[7:0];
    msk = 8'h01 << it.bit_index;
    cy  = 1'b0;
    // unknown codes pass everything through
    o.result = it.left;
    o.zero   = it.zi;
    o.sub    = it.ni;
    o.half   = it.hi;
    o.carry  = it.ci;
    case (it.op)
      sm83_alu_pkg::OP_ADD, sm83_alu_pkg::OP_ADC: begin
        if (it.op == sm83_alu_pkg::OP_ADC) cy = it.ci;
        s9 = {1'b0, a} + {1'b0, b} + {8'h00, cy};
        h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
        o  = pack8(s9[7:0], s9[7:0] == 8'h00, 1'b0, h5[4], s9[8]);
      end
      sm83_alu_pkg::OP_SUB, sm83_alu_pkg::OP_SBC, sm83_alu_pkg::OP_CP: begin
        if (it.op == sm83_alu_pkg::OP_SBC) cy = it.ci;
        r8 = a - b - {7'h00, cy};
        o  = pack8((it.op == sm83_alu_pkg::OP_CP) ? a : r8, r8 == 8'h00, 1'b1,
                   {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, cy}),
                   {1'b0, a} < ({1'b0, b} + {8'h00, cy}));
      end
      sm83_alu_pkg::OP_AND: o = pack8(a & b, (a & b) == 8'h00, 1'b0, 1'b1, 1'b0);
      sm83_alu_pkg::OP_XOR: o = pack8(a ^ b, (a ^ b) == 8'h00, 1'b0, 1'b0, 1'b0);
      sm83_alu_pkg::OP_OR:  o = pack8(a | b, (a | b) == 8'h00, 1'b0, 1'b0, 1'b0);
      sm83_alu_pkg::OP_INC: begin
        r8 = a + 8'h01;
        o  = pack8(r8, r8 == 8'h00, 1'b0, a[3:0] == 4'hF, it.ci);
      end
      sm83_alu_pkg::OP_DEC: begin
        r8 = a - 8'h01;
        o  = pack8(r8, r8 == 8'h00, 1'b1, a[3:0] == 4'h0, it.ci);
      end
      sm83_alu_pkg::OP_DAA: begin
        adj = 8'h00;
        cy  = it.ci;
        if (it.hi || (!it.ni && a[3:0] > 4'h9)) adj = adj | 8'h06;
        if (it.ci || (!it.ni && a > 8'h99)) begin
          adj = adj | 8'h60;
          cy  = 1'b1;
        end
        r8 = it.ni ? (a - adj) : (a + adj);
        o  = pack8(r8, r8 == 8'h00, it.ni, 1'b0, cy);
      end
      sm83_alu_pkg::OP_CPL: o = pack8(~a, it.zi, 1'b1, 1'b1, it.ci);
      sm83_alu_pkg::OP_SCF: o = pack8(a, it.zi, 1'b0, 1'b0, 1'b1);
      sm83_alu_pkg::OP_CCF: o = pack8(a, it.zi, 1'b0, 1'b0, ~it.ci);
      sm83_alu_pkg::OP_RLC, sm83_alu_pkg::OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        o  = pack8(r8, (it.op != sm83_alu_pkg::OP_RLCA) && (r8 == 8'h00),
                   1'b0, 1'b0, a[7]);
      end
      sm83_alu_pkg::OP_RRC, sm83_alu_pkg::OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        o  = pack8(r8, (it.op != sm83_alu_pkg::OP_RRCA) && (r8 == 8'h00),
                   1'b0, 1'b0, a[0]);
      end
      sm83_alu_pkg::OP_RL, sm83_alu_pkg::OP_RLA: begin
        r8 = {a[6:0], it.ci};
        o  = pack8(r8, (it.op != sm83_alu_pkg::OP_RLA) && (r8 == 8'h00),
                   1'b0, 1'b0, a[7]);
      end
      sm83_alu_pkg::OP_RR, sm83_alu_pkg::OP_RRA: begin
        r8 = {it.ci, a[7:1]};
        o  = pack8(r8, (it.op != sm83_alu_pkg::OP_RRA) && (r8 == 8'h00),
                   1'b0, 1'b0, a[0]);
      end
      sm83_alu_pkg::OP_SLA:
        o = pack8({a[6:0], 1'b0}, a[6:0] == 7'h00, 1'b0, 1'b0, a[7]);
      sm83_alu_pkg::OP_SRA:
        o = pack8({a[7], a[7:1]}, a[7:1] == 7'h00, 1'b0, 1'b0, a[0]);
      sm83_alu_pkg::OP_SWAP:
        o = pack8({a[3:0], a[7:4]}, a == 8'h00, 1'b0, 1'b0, 1'b0);
      sm83_alu_pkg::OP_SRL:
        o = pack8({1'b0, a[7:1]}, a[7:1] == 7'h00, 1'b0, 1'b0, a[0]);
      sm83_alu_pkg::OP_BIT: o = pack8(a, (a & msk) == 8'h00, 1'b0, 1'b1, it.ci);
      sm83_alu_pkg::OP_RES: o = pack8(a & ~msk, it.zi, it.ni, it.hi, it.ci);
      sm83_alu_pkg::OP_SET: o = pack8(a | msk, it.zi, it.ni, it.hi, it.ci);
      sm83_alu_pkg::OP_ADD16: begin
        s17 = {1'b0, it.left} + {1'b0, it.right};
        h13 = {1'b0, it.left[11:0]} + {1'b0, it.right[11:0]};
        o.result = s17[15:0];
        o.zero   = it.zi;
        o.sub    = 1'b0;
        o.half   = h13[12];
        o.carry  = s17[16];
      end
      sm83_alu_pkg::OP_ADD_SP: begin
        s9 = {1'b0, it.left[7:0]} + {1'b0, b};
        h5 = {1'b0, it.left[3:0]} + {1'b0, b[3:0]};
        o.result = it.left + {{8{b[7]}}, b};
        o.zero   = 1'b0;
        o.sub    = 1'b0;
        o.half   = h5[4];
        o.carry  = s9[8];
      end
      default: ;
    endcase
    return o;
  endfunction

  function void note_op(sm83_alu_pkg::item_t it);
    pending_outs.push_back(alu_eval(it));
    ops_seen[it.op] = 1'b1;
    n_ops++;
  endfunction

  function void check_result(sm83_alu_pkg::out_t got);
    sm83_alu_pkg::out_t want;
    if (pending_outs.size() == 0) begin
      $error("unexpected result %h with no operation outstanding", got.result);
      n_fails++;
      return;
    end
    want = pending_outs.pop_front();
    n_checked++;
    if (got.result !== want.result) begin
      $error("result: expected %h, got %h", want.result, got.result);
      n_fails++;
    end
    if (got.zero !== want.zero) begin
      $error("zero_out: expected %b, got %b", want.zero, got.zero);
      n_fails++;
    end
    if (got.sub !== want.sub) begin
      $error("sub_out: expected %b, got %b", want.sub, got.sub);
      n_fails++;
    end
    if (got.half !== want.half) begin
      $error("half_out: expected %b, got %b", want.half, got.half);
      n_fails++;
    end
    if (got.carry !== want.carry) begin
      $error("carry_out: expected %b, got %b", want.carry, got.carry);
      n_fails++;
    end
  endfunction
endclass

module tb_sm83_alu_with_flags;
  localparam int QUIET_LIMIT = 500;

  logic        clk;
  logic        rst_n;
  int          tx_idle_max;
  int          rx_idle_max;
  int          quiet = 0;
  alu_checker  sb;

  sm83_alu_in_if  in_ch ();
  sm83_alu_out_if out_ch ();

  sm83_alu_with_flags DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_op(input sm83_alu_pkg::item_t it);
    int gap;
    gap = $urandom_range(tx_idle_max, 0);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op        = it.op;
    in_ch.left      = it.left;
    in_ch.right     = it.right;
    in_ch.bit_index = it.bit_index;
    in_ch.zero_in   = it.zi;
    in_ch.sub_in    = it.ni;
    in_ch.half_in   = it.hi;
    in_ch.carry_in  = it.ci;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_op(it);
    @(negedge clk);
  endtask

  task automatic send_fields(input sm83_alu_pkg::op_t op, input logic [15:0] l,
                             input logic [15:0] r, input logic [2:0] bi,
                             input logic [3:0] znhc);
    sm83_alu_pkg::item_t it;
    it = '{op, l, r, bi, znhc[3], znhc[2], znhc[1], znhc[0]};
    send_op(it);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid = 1'b0;
    do @(negedge clk); while (sb.pending_outs.size() != 0);
  endtask

  function automatic logic [15:0] pick_word();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(7, 0))
      0: w = 16'h0000;
      1: w = 16'hFFFF;
      2: w[7:0] = 8'hFF;
      3: w[7:0] = 8'h00;
      4: begin
        case ($urandom_range(5, 0))
          0: w[7:0] = 8'h0F;
          1: w[7:0] = 8'h10;
          2: w[7:0] = 8'h7F;
          3: w[7:0] = 8'h80;
          4: w[7:0] = 8'h99;
          default: w[7:0] = 8'h9A;
        endcase
      end
      5: w[11:0] = 12'hFFF;
      default: ;
    endcase
    return w;
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(3, 0))
      0: return 0;
      1: return 3;
      default: return 18;
    endcase
  endfunction

  // Result side: stall at random, then take one result and check it.
  initial begin
    int                 gap;
    sm83_alu_pkg::out_t got;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = $urandom_range(rx_idle_max, 0);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.result = out_ch.result;
      got.zero   = out_ch.zero_out;
      got.sub    = out_ch.sub_out;
      got.half   = out_ch.half_out;
      got.carry  = out_ch.carry_out;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet = quiet + 1;
    end
  end

  initial begin
    sm83_alu_pkg::item_t it;
    sb              = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = 5'd0;
    in_ch.left      = 16'h0000;
    in_ch.right     = 16'h0000;
    in_ch.bit_index = 3'd0;
    in_ch.zero_in   = 1'b0;
    in_ch.sub_in    = 1'b0;
    in_ch.half_in   = 1'b0;
    in_ch.carry_in  = 1'b0;
    tx_idle_max     = 18;
    rx_idle_max     = 18;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, every operation, flag corner cases
    send_fields(sm83_alu_pkg::OP_ADD,    16'hAB0F, 16'h12F1, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_ADC,    16'h00FF, 16'hFF00, 3'd0, 4'b0001);
    send_fields(sm83_alu_pkg::OP_SUB,    16'h0000, 16'h0001, 3'd0, 4'b1000);
    send_fields(sm83_alu_pkg::OP_SBC,    16'h0010, 16'h000F, 3'd0, 4'b0001);
    send_fields(sm83_alu_pkg::OP_CP,     16'hFF3C, 16'h003C, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_AND,    16'hFFFF, 16'hFFFF, 3'd7, 4'b1111);
    send_fields(sm83_alu_pkg::OP_XOR,    16'h005A, 16'hA55A, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_OR,     16'h0000, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_INC,    16'h00FF, 16'h0000, 3'd0, 4'b0001);
    send_fields(sm83_alu_pkg::OP_DEC,    16'h0010, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_DAA,    16'h009A, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_DAA,    16'h0000, 16'h0000, 3'd0, 4'b0111);
    send_fields(sm83_alu_pkg::OP_CPL,    16'h00FF, 16'h0000, 3'd0, 4'b1001);
    send_fields(sm83_alu_pkg::OP_SCF,    16'hFF5A, 16'h0000, 3'd0, 4'b1110);
    send_fields(sm83_alu_pkg::OP_CCF,    16'h00A5, 16'h0000, 3'd0, 4'b0001);
    send_fields(sm83_alu_pkg::OP_RLC,    16'h0080, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_RRC,    16'h0001, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_RL,     16'h0080, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_RR,     16'h0000, 16'h0000, 3'd0, 4'b0001);
    send_fields(sm83_alu_pkg::OP_SLA,    16'h0080, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_SRA,    16'h0081, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_SWAP,   16'h00F0, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_SRL,    16'h0001, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_BIT,    16'h007F, 16'h0000, 3'd7, 4'b0001);
    send_fields(sm83_alu_pkg::OP_RES,    16'h00FF, 16'h0000, 3'd0, 4'b1111);
    send_fields(sm83_alu_pkg::OP_SET,    16'h0000, 16'h0000, 3'd7, 4'b0000);
    send_fields(sm83_alu_pkg::OP_RLCA,   16'h0000, 16'h0000, 3'd0, 4'b1000);
    send_fields(sm83_alu_pkg::OP_RRCA,   16'h0001, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_RLA,    16'h0080, 16'h0000, 3'd0, 4'b0001);
    send_fields(sm83_alu_pkg::OP_RRA,    16'h0001, 16'h0000, 3'd0, 4'b0000);
    send_fields(sm83_alu_pkg::OP_ADD16,  16'hFFFF, 16'h0001, 3'd0, 4'b1000);
    send_fields(sm83_alu_pkg::OP_ADD_SP, 16'hFFFF, 16'hAB80, 3'd0, 4'b1111);
    drain_results();

    // Random: blocks with their own idle pattern on each side
    for (int blk = 0; blk < 9; blk++) begin
      tx_idle_max = pick_idle();
      rx_idle_max = pick_idle();
      for (int i = 0; i < 50; i++) begin
        it.op        = sm83_alu_pkg::op_t'($urandom_range(30, 0));
        it.left      = pick_word();
        it.right     = pick_word();
        it.bit_index = 3'($urandom_range(7, 0));
        it.zi        = 1'($urandom);
        it.ni        = 1'($urandom);
        it.hi        = 1'($urandom);
        it.ci        = 1'($urandom);
        send_op(it);
      end
      if (blk % 3 == 2) drain_results();
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("Ran %0d operations covering %0d of 31 codes; %0d results checked.",
             sb.n_ops, $countones(sb.ops_seen), sb.n_checked);
    if (sb.n_fails == 0 && sb.pending_outs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
